@@ rtl/afce_pkg.sv @@
// Shared types, constants and helper functions for the ASCII fire cell engine.
// No dependencies; afce_ctrl, afce_dp and the top unit import this package.
package afce_pkg;

    // Grid geometry
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_CELLS   = MAX_COLUMNS * MAX_ROWS;
    localparam int GRID_DEPTH  = MAX_CELLS + MAX_COLUMNS + 1;

    // Field and internal widths
    localparam int COL_W    = 8;                       // grid_columns register
    localparam int ROW_W    = 7;                       // grid_rows register
    localparam int SEED_W   = 7;                       // seed_column field
    localparam int HEAT_W   = 7;
    localparam int GLYPH_W  = 7;
    localparam int COLOR_W  = 24;
    localparam int CIDX_W   = 13;                      // cell_index field
    localparam int SUM_W    = HEAT_W + 2;
    localparam int IDX_W    = $clog2(MAX_CELLS);
    localparam int SIZE_W   = $clog2(MAX_CELLS + 1);
    localparam int ADDR_W   = $clog2(GRID_DEPTH);
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Request codes
    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_CELL = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // Neighbor read select
    localparam logic [1:0] RD_SEL_SELF  = 2'd0;
    localparam logic [1:0] RD_SEL_RIGHT = 2'd1;
    localparam logic [1:0] RD_SEL_BELOW = 2'd2;
    localparam logic [1:0] RD_SEL_DIAG  = 2'd3;

    // Heat thresholds and colors (0xBBGGRR)
    localparam logic [HEAT_W-1:0]  FULL_HEAT  = 7'd65;
    localparam logic [HEAT_W-1:0]  HEAT_HOT   = 7'd15;
    localparam logic [HEAT_W-1:0]  HEAT_WARM  = 7'd9;
    localparam logic [HEAT_W-1:0]  HEAT_DIM   = 7'd4;
    localparam logic [COLOR_W-1:0] COLOR_HOT  = 24'hBD8F63;
    localparam logic [COLOR_W-1:0] COLOR_WARM = 24'h55FFFF;
    localparam logic [COLOR_W-1:0] COLOR_DIM  = 24'h5555FF;
    localparam logic [COLOR_W-1:0] COLOR_COLD = 24'h808080;

    // Glyph ramp " .:^*xsS#$"
    localparam int RAMP_LEVELS = 10;
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;
    localparam logic [GLYPH_W-1:0] GLYPH_RAMP [RAMP_LEVELS] =
        '{7'd32, 7'd46, 7'd58, 7'd94, 7'd42, 7'd120, 7'd115, 7'd83, 7'd35, 7'd36};

    // Controller -> datapath commands
    typedef struct packed {
        logic       clr_start;   // restart clear pass, zero cursor
        logic       clr_wr;      // write one zero entry of the clear pass
        logic       seed_wr;     // apply seed beat (datapath checks the column)
        logic       idx_load;    // latch the cell index at the cursor
        logic       rd_issue;    // issue one grid read
        logic [1:0] rd_sel;      // which neighbor to read
        logic       sum_clear;   // start sum with returned heat
        logic       sum_add;     // add returned heat to sum
        logic       commit;      // write back heat, load result register
    } afce_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic slot_free;         // result register free at this edge
        logic clr_done;          // clear pass on its last entry
    } afce_stat_t;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [HEAT_W-1:0] heat);
        logic [3:0] lvl;
        lvl = (heat > HEAT_WARM) ? 4'(RAMP_LEVELS - 1) : heat[3:0];
        return GLYPH_RAMP[lvl];
    endfunction

    function automatic logic [COLOR_W-1:0] color_of(input logic [HEAT_W-1:0] heat);
        logic [COLOR_W-1:0] c;
        priority if (heat > HEAT_HOT)  c = COLOR_HOT;
        else if (heat > HEAT_WARM)     c = COLOR_WARM;
        else if (heat > HEAT_DIM)      c = COLOR_DIM;
        else                           c = COLOR_COLD;
        return c;
    endfunction

endpackage

@@ rtl/afce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module afce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/afce_ctrl.sv @@
// Controller state machine: clear pass, seed beats and the per-cell read sequence.
// Depends on afce_pkg.
module afce_ctrl import afce_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       req_type,
    input  logic       size_change,
    input  afce_stat_t stat,
    output logic       in_ready,
    output afce_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD1   = 3'd2;
    localparam logic [2:0] ST_RD2   = 3'd3;
    localparam logic [2:0] ST_RD3   = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.rd_sel    = RD_SEL_SELF;
        cmd.clr_start = size_change;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = !size_change;
                if (stat.clr_done && !size_change)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == REQ_SEED)
                    begin
                        cmd.seed_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_load = 1'b1;
                        cmd.rd_issue = 1'b1;
                        cmd.rd_sel   = RD_SEL_SELF;
                        state_next   = ST_RD1;
                    end
                end
            end
            ST_RD1:
            begin
                cmd.rd_issue  = 1'b1;
                cmd.rd_sel    = RD_SEL_RIGHT;
                cmd.sum_clear = 1'b1;
                state_next    = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.rd_issue = 1'b1;
                cmd.rd_sel   = RD_SEL_BELOW;
                cmd.sum_add  = 1'b1;
                state_next   = ST_RD3;
            end
            ST_RD3:
            begin
                cmd.rd_issue = 1'b1;
                cmd.rd_sel   = RD_SEL_DIAG;
                cmd.sum_add  = 1'b1;
                state_next   = ST_WB;
            end
            ST_WB:
            begin
                if (stat.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (size_change)
        begin
            state_next = ST_CLEAR;
        end
    end

endmodule

@@ rtl/afce_dp.sv @@
// Datapath: cursor, neighbor addressing, heat sum, glyph/color lookup, result register.
// Depends on afce_pkg and afce_ram.
module afce_dp import afce_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COL_W-1:0]   grid_columns,
    input  logic [ROW_W-1:0]   grid_rows,
    input  logic [SEED_W-1:0]  seed_column,
    input  afce_cmd_t          cmd,
    output afce_stat_t         stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [CIDX_W-1:0]  cell_index,
    output logic [HEAT_W-1:0]  heat_value,
    output logic [GLYPH_W-1:0] glyph_code,
    output logic [COLOR_W-1:0] color_rgb,
    output logic               draw_flag,
    output logic               frame_last
);

    logic [COL_W+ROW_W-1:0] size_full;
    logic [SIZE_W-1:0]      size;
    logic [IDX_W-1:0]       cursor_reg;
    logic [IDX_W-1:0]       cursor_next;
    logic [IDX_W-1:0]       cur_idx;
    logic [IDX_W-1:0]       idx_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       total;
    logic [HEAT_W-1:0]      heat;
    logic [GLYPH_W-1:0]     glyph;
    logic                   last;
    logic                   seed_hit;
    logic [ADDR_W-1:0]      seed_addr;
    logic [ADDR_W-1:0]      idx_addr;
    logic [ADDR_W-1:0]      cols_addr;
    logic [ADDR_W-1:0]      raddr;
    logic [ADDR_W-1:0]      waddr;
    logic [HEAT_W-1:0]      wdata;
    logic                   we;
    logic [HEAT_W-1:0]      rdata;
    logic                   out_valid_reg;
    logic [CIDX_W-1:0]      cell_index_reg;
    logic [HEAT_W-1:0]      heat_value_reg;
    logic [GLYPH_W-1:0]     glyph_code_reg;
    logic [COLOR_W-1:0]     color_rgb_reg;
    logic                   draw_flag_reg;
    logic                   frame_last_reg;

    assign size_full = (COL_W+ROW_W)'(grid_columns) * (COL_W+ROW_W)'(grid_rows);
    assign size      = size_full[SIZE_W-1:0];

    // Wrap a stale cursor back to the first cell
    assign cur_idx = (SIZE_W'(cursor_reg) >= size) ? '0 : cursor_reg;

    assign idx_addr  = ADDR_W'(idx_reg);
    assign cols_addr = ADDR_W'(grid_columns);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_SEL_SELF:  raddr = ADDR_W'(cur_idx);
            RD_SEL_RIGHT: raddr = idx_addr + ADDR_W'(1);
            RD_SEL_BELOW: raddr = idx_addr + cols_addr;
            RD_SEL_DIAG:  raddr = idx_addr + cols_addr + ADDR_W'(1);
            default:      raddr = ADDR_W'(cur_idx);
        endcase
    end

    // Bottom row starts at size - columns
    assign seed_hit  = cmd.seed_wr && (COL_W'(seed_column) < grid_columns);
    assign seed_addr = ADDR_W'(size) - cols_addr + ADDR_W'(seed_column);

    // Heat of the cell: floor of the mean of the cell and its right, below and diagonal neighbors
    assign total = sum_reg + SUM_W'(rdata);
    assign heat  = total[SUM_W-1:2];
    assign glyph = glyph_of(heat);
    assign last  = (SIZE_W'(idx_reg) == size - SIZE_W'(1));

    always_comb
    begin
        priority if (cmd.clr_wr)
        begin
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else if (cmd.commit)
        begin
            waddr = idx_addr;
            wdata = heat;
        end
        else
        begin
            waddr = seed_addr;
            wdata = FULL_HEAT;
        end
    end

    assign we = cmd.clr_wr || cmd.commit || seed_hit;

    afce_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        cursor_next = cursor_reg;
        if (cmd.clr_start)
        begin
            cursor_next = '0;
        end
        else if (cmd.commit)
        begin
            cursor_next = last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            if (cmd.clr_start)
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.idx_load)
        begin
            idx_reg <= cur_idx;
        end
        if (cmd.sum_clear)
        begin
            sum_reg <= SUM_W'(rdata);
        end
        else if (cmd.sum_add)
        begin
            sum_reg <= total;
        end
        if (cmd.commit)
        begin
            cell_index_reg <= CIDX_W'(idx_reg);
            heat_value_reg <= heat;
            glyph_code_reg <= glyph;
            color_rgb_reg  <= color_of(heat);
            draw_flag_reg  <= (glyph != GLYPH_SPACE) && !last;
            frame_last_reg <= last;
        end
    end

    assign stat.slot_free = !out_valid_reg || out_ready;
    assign stat.clr_done  = (clr_cnt_reg == ADDR_W'(GRID_DEPTH - 1));

    assign out_valid  = out_valid_reg;
    assign cell_index = cell_index_reg;
    assign heat_value = heat_value_reg;
    assign glyph_code = glyph_code_reg;
    assign color_rgb  = color_rgb_reg;
    assign draw_flag  = draw_flag_reg;
    assign frame_last = frame_last_reg;

endmodule

@@ rtl/ascii_fire_cell_engine_unit.sv @@
// Result: a cell beat gives one result, registered at its write-back; a seed beat gives none.
// Throughput: one seed beat per cycle while idle; no beat is taken while a cell is in
// flight, as the single read port of the grid memory serves its four reads in turn.
// Reset: async, active low; the grid is then zeroed by a clear pass over its 8321 entries
// (one entry a cycle), rerun after any size change, during which no beat is accepted.
// Depends on afce_pkg, afce_ctrl, afce_dp and afce_ram.
module ascii_fire_cell_engine_unit import afce_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    // APB-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [SEED_W-1:0]  seed_column,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CIDX_W-1:0]  cell_index,
    output logic [HEAT_W-1:0]  heat_value,
    output logic [GLYPH_W-1:0] glyph_code,
    output logic [COLOR_W-1:0] color_rgb,
    output logic               draw_flag,
    output logic               frame_last
);

    logic [COL_W-1:0] grid_columns_reg;
    logic [COL_W-1:0] grid_columns_next;
    logic [ROW_W-1:0] grid_rows_reg;
    logic [ROW_W-1:0] grid_rows_next;
    logic [COL_W-1:0] cols_clamped;
    logic [ROW_W-1:0] rows_clamped;
    logic             cfg_wr;
    logic             size_change;
    afce_cmd_t        cmd;
    afce_stat_t       stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Clamp written sizes into 1..max; the register keeps the clamped value
    always_comb
    begin
        priority if (pwdata[COL_W-1:0] == '0)
        begin
            cols_clamped = COL_W'(1);
        end
        else if (pwdata[COL_W-1:0] > COL_W'(MAX_COLUMNS))
        begin
            cols_clamped = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            cols_clamped = pwdata[COL_W-1:0];
        end
        priority if (pwdata[ROW_W-1:0] == '0)
        begin
            rows_clamped = ROW_W'(1);
        end
        else if (pwdata[ROW_W-1:0] > ROW_W'(MAX_ROWS))
        begin
            rows_clamped = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows_clamped = pwdata[ROW_W-1:0];
        end
    end

    // A write of the current size changes nothing; a new size restarts the clear pass
    always_comb
    begin
        grid_columns_next = grid_columns_reg;
        grid_rows_next    = grid_rows_reg;
        size_change       = 1'b0;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_COLUMNS:
                begin
                    if (cols_clamped != grid_columns_reg)
                    begin
                        grid_columns_next = cols_clamped;
                        size_change       = 1'b1;
                    end
                end
                REG_ROWS:
                begin
                    if (rows_clamped != grid_rows_reg)
                    begin
                        grid_rows_next = rows_clamped;
                        size_change    = 1'b1;
                    end
                end
                default:
                begin
                    size_change = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= COL_W'(80);
            grid_rows_reg    <= ROW_W'(25);
        end
        else
        begin
            grid_columns_reg <= grid_columns_next;
            grid_rows_reg    <= grid_rows_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_COLUMNS: prdata = PDATA_W'(grid_columns_reg);
            REG_ROWS:    prdata = PDATA_W'(grid_rows_reg);
            default:     prdata = '0;
        endcase
    end

    // Sequencer: clear pass, seed writes, four reads and a write-back per cell
    afce_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .req_type    (req_type),
        .size_change (size_change),
        .stat        (stat),
        .in_ready    (in_ready),
        .cmd         (cmd)
    );

    // Grid memory, cursor, averaging and the result register
    afce_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_columns (grid_columns_reg),
        .grid_rows    (grid_rows_reg),
        .seed_column  (seed_column),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .cell_index   (cell_index),
        .heat_value   (heat_value),
        .glyph_code   (glyph_code),
        .color_rgb    (color_rgb),
        .draw_flag    (draw_flag),
        .frame_last   (frame_last)
    );

    // A new size blocks beats while the grid is cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        size_change |=> !in_ready)
        else $error("beat taken during clear pass");

    // A cell beat holds the request side until its write-back
    a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type == REQ_CELL) |=> !in_ready)
        else $error("second beat taken while a cell is in flight");

    // A write-back always presents a result on the next cycle
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed cell not presented");

    // The frame's last cell is never drawn
    a_last_not_drawn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> !draw_flag)
        else $error("last cell flagged for drawing");

endmodule
